@@ src/krev_pkg.sv @@
// Shared constants, types and state codes of the k-group block reverser.
package krev_pkg;

  localparam int MAX_GROUP  = 16;
  localparam int DATA_WIDTH = 32;

  // Group size register.
  localparam int                 CFG_W      = 5;
  localparam logic [CFG_W-1:0]   GROUP_RST  = CFG_W'(1);

  // Largest group the design is built for sets the descriptor field widths.
  localparam int GROUP_LIMIT = 64;
  localparam int CNT_W_MAX   = $clog2(GROUP_LIMIT + 1);

  // Descriptor queue between the front and the back.
  localparam int DQ_DEPTH = 2;
  localparam int DQ_PTR_W = $clog2(DQ_DEPTH);
  localparam int DQ_CNT_W = $clog2(DQ_DEPTH + 1);

  // Result queue at the output.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // One closed group: which bank holds it, how many words, and how to drain it.
  typedef struct packed {
    logic                 bank;
    logic [CNT_W_MAX-1:0] count;
    logic                 reverse;
    logic                 list_end;
  } desc_t;

  // Bank hand-back from the back to the front.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

endpackage

@@ src/krev_desc_q.sv @@
// Two-entry queue of group descriptors between the front and the back.
module krev_desc_q (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  krev_pkg::desc_t   desc_i,
  input  logic              pop_i,
  output krev_pkg::desc_t   desc_o,
  output logic              empty_o,
  output logic              full_o
);
  import krev_pkg::*;

  desc_t               entry_q [DQ_DEPTH];
  logic [DQ_PTR_W-1:0] wptr_q, wptr_d;
  logic [DQ_PTR_W-1:0] rptr_q, rptr_d;
  logic [DQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == DQ_CNT_W'(0));
  assign full_o  = (cnt_q == DQ_CNT_W'(DQ_DEPTH));
  assign desc_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + DQ_PTR_W'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + DQ_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + DQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - DQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

  // The front only closes a group into a free bank, so the queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("descriptor pushed into a full queue");

endmodule

@@ src/krev_front.sv @@
// Front: holds the group size, writes words into the banks and closes groups.
module krev_front #(
  parameter int MaxGroup  = krev_pkg::MAX_GROUP,
  parameter int DataWidth = krev_pkg::DATA_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               group_size_we_i,
  input  logic [krev_pkg::CFG_W-1:0]         group_size_i,
  input  logic                               push,
  output logic                               full,
  input  logic signed [DataWidth-1:0]        data_word_i,
  input  logic                               list_end_i,
  output logic                               wr_en_o,
  output logic [$clog2(MaxGroup):0]          wr_addr_o,
  output logic [DataWidth-1:0]               wr_data_o,
  output logic                               desc_push_o,
  output krev_pkg::desc_t                    desc_o,
  input  krev_pkg::release_t                 release_i
);
  import krev_pkg::*;

  localparam int AW   = $clog2(MaxGroup);
  localparam int CntW = $clog2(MaxGroup + 1);

  logic [CFG_W-1:0] gsize_q;
  logic [AW-1:0]    fill_q, fill_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;
  logic [CntW-1:0]  g_eff, n_words;
  logic             accept, do_rev, close;

  always_comb begin
    if (gsize_q == '0) begin
      g_eff = CntW'(1);
    end else if (32'(gsize_q) > 32'(MaxGroup)) begin
      g_eff = CntW'(MaxGroup);
    end else begin
      g_eff = CntW'(gsize_q);
    end
  end

  assign full    = busy_q[bank_q];
  assign accept  = push && !full;
  assign n_words = CntW'(fill_q) + CntW'(1);
  assign do_rev  = (n_words >= g_eff);
  assign close   = do_rev || list_end_i;

  assign wr_en_o   = accept;
  assign wr_addr_o = {bank_q, fill_q};
  assign wr_data_o = data_word_i;

  assign desc_push_o      = accept && close;
  assign desc_o.bank      = bank_q;
  assign desc_o.count     = CNT_W_MAX'(n_words);
  assign desc_o.reverse   = do_rev;
  assign desc_o.list_end  = list_end_i;

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (accept) begin
      if (close) begin
        fill_d         = '0;
        bank_d         = !bank_q;
        busy_d[bank_q] = 1'b1;
      end else begin
        fill_d = fill_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q <= GROUP_RST;
      fill_q  <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      if (group_size_we_i) begin
        gsize_q <= group_size_i;
      end
      fill_q <= fill_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

  // A bank that is handed back must have been closed before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   release_i.valid |-> busy_q[release_i.bank])
    else $error("release of a bank that was not in use");

endmodule

@@ src/krev_back.sv @@
// Back: bank memory, drains closed groups in order and queues the results.
module krev_back #(
  parameter int MaxGroup  = krev_pkg::MAX_GROUP,
  parameter int DataWidth = krev_pkg::DATA_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [$clog2(MaxGroup):0]      wr_addr_i,
  input  logic [DataWidth-1:0]           wr_data_i,
  input  krev_pkg::desc_t                desc_i,
  input  logic                           desc_empty_i,
  output logic                           desc_pop_o,
  output krev_pkg::release_t             release_o,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [DataWidth-1:0]    out_word_o,
  output logic                           run_last_o,
  output logic                           list_done_o
);
  import krev_pkg::*;

  localparam int AW       = $clog2(MaxGroup);
  localparam int CntW     = $clog2(MaxGroup + 1);
  localparam int MemDepth = 2 * (2 ** AW);

  typedef struct packed {
    logic [DataWidth-1:0] word;
    logic                 last;
    logic                 done;
  } res_t;

  logic [DataWidth-1:0] mem [MemDepth];

  bk_state_e            state_q, state_d;
  desc_t                cur_q;
  logic [AW-1:0]        idx_q;
  logic [CntW-1:0]      cnt, last_idx;
  logic [AW-1:0]        rd_idx;
  logic                 space, issue, last_issue;

  logic [DataWidth-1:0] rd_data_q;
  logic                 rd_v_q, rd_last_q, rd_done_q;

  res_t                 out_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owptr_q, orptr_q;
  logic [OUT_CNT_W-1:0] ocnt_q, ocnt_d;
  logic                 out_pop;

  assign cnt      = cur_q.count[CntW-1:0];
  assign last_idx = cnt - CntW'(1);
  assign rd_idx   = cur_q.reverse ? AW'(last_idx - CntW'(idx_q)) : idx_q;
  assign space    = (OUT_CNT_W'(ocnt_q) + OUT_CNT_W'(rd_v_q)) < OUT_CNT_W'(OUT_DEPTH);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!desc_empty_i) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (last_issue && desc_empty_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the drain sequencer.
  always_comb begin
    issue      = 1'b0;
    last_issue = 1'b0;
    desc_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        desc_pop_o = !desc_empty_i;
      end
      BK_RUN: begin
        issue      = space;
        last_issue = space && (CntW'(idx_q) == last_idx);
        desc_pop_o = last_issue && !desc_empty_i;
      end
      default: ;
    endcase
  end

  assign release_o.valid = last_issue;
  assign release_o.bank  = cur_q.bank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      if (desc_pop_o) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_pop_o) begin
      cur_q <= desc_i;
    end
  end

  // Bank memory: one write port from the front, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem[{cur_q.bank, rd_idx}];
      rd_last_q <= last_issue;
      rd_done_q <= last_issue && cur_q.list_end;
    end
  end

  // Result queue.
  assign empty   = (ocnt_q == '0);
  assign out_pop = pop && !empty;

  always_comb begin
    ocnt_d = ocnt_q;
    if (rd_v_q && !out_pop) begin
      ocnt_d = ocnt_q + OUT_CNT_W'(1);
    end else if (out_pop && !rd_v_q) begin
      ocnt_d = ocnt_q - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      ocnt_q <= ocnt_d;
      if (rd_v_q) begin
        owptr_q <= owptr_q + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        orptr_q <= orptr_q + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      out_q[owptr_q] <= '{word: rd_data_q, last: rd_last_q, done: rd_done_q};
    end
  end

  assign out_word_o  = out_q[orptr_q].word;
  assign run_last_o  = out_q[orptr_q].last;
  assign list_done_o = out_q[orptr_q].done;

  // A read is only started when its result has a place in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (OUT_CNT_W'(ocnt_q) + OUT_CNT_W'(rd_v_q)) <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overrun");

  // A finished list always closes a group, so list_done implies run_last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (rd_v_q && rd_done_q) |-> rd_last_q)
    else $error("list end flagged on a word that does not close its group");

  // Reads only happen while a group is being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rd_v_q |-> $past(state_q) == BK_RUN)
    else $error("bank read outside a drain");

endmodule

@@ src/k_group_block_reverser.sv @@
// Top level of the k-group block reverser: front, descriptor queue and back.
//
// Usage: list words enter through a queue-style port (push/full) together
// with list_end on the final word of a list. Words are collected into one of
// two memory banks. A group closes when group_size words are held, or when
// list_end arrives; a full group is emitted newest word first, a short group
// at the end of a list in arrival order. Results leave through a second
// queue-style port (empty/pop): run_last marks the last word of each group,
// list_done the last word of the list. group_size is written through
// group_size_we_i/group_size_i while the block is idle; 0 acts as 1 and values
// above MaxGroup act as MaxGroup.
// Banking: the two banks alternate, so one group drains while the next
// fills. The input stalls while both banks hold undrained groups.
// With the back idle, the first result of a closed group passes the
// descriptor queue, the drain's descriptor register, the memory read register
// and the result queue. Reset empties both banks, both queues and sets
// group_size to 1. When the receiver stalls, the four-entry result queue
// fills, draining pauses and the banks stay held until it moves again.
module k_group_block_reverser #(
  parameter int MaxGroup  = krev_pkg::MAX_GROUP,
  parameter int DataWidth = krev_pkg::DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         group_size_we_i,
  input  logic [krev_pkg::CFG_W-1:0]   group_size_i,
  input  logic                         push,
  output logic                         full,
  input  logic signed [DataWidth-1:0]  data_word_i,
  input  logic                         list_end_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DataWidth-1:0]  out_word_o,
  output logic                         run_last_o,
  output logic                         list_done_o
);
  import krev_pkg::*;

  logic                        wr_en;
  logic [$clog2(MaxGroup):0]   wr_addr;
  logic [DataWidth-1:0]        wr_data;
  logic                        desc_push, desc_pop, desc_empty, desc_full;
  desc_t                       desc_in, desc_out;
  release_t                    bank_release;

  krev_front #(
    .MaxGroup (MaxGroup),
    .DataWidth(DataWidth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .group_size_we_i(group_size_we_i),
    .group_size_i   (group_size_i),
    .push           (push),
    .full           (full),
    .data_word_i    (data_word_i),
    .list_end_i     (list_end_i),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .desc_push_o    (desc_push),
    .desc_o         (desc_in),
    .release_i      (bank_release)
  );

  krev_desc_q u_desc_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (desc_push),
    .desc_i (desc_in),
    .pop_i  (desc_pop),
    .desc_o (desc_out),
    .empty_o(desc_empty),
    .full_o (desc_full)
  );

  krev_back #(
    .MaxGroup (MaxGroup),
    .DataWidth(DataWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .desc_i      (desc_out),
    .desc_empty_i(desc_empty),
    .desc_pop_o  (desc_pop),
    .release_o   (bank_release),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o),
    .run_last_o  (run_last_o),
    .list_done_o (list_done_o)
  );

  // Each open descriptor owns one bank, so the queue is full only when the
  // front is holding off input.
  assert property (@(posedge clk_i) disable iff (!rst_ni) desc_full |-> full)
    else $error("descriptor queue full while input is open");

endmodule
